// ===== rtl/core/rmq_pkg.sv =====
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int THR_W     = 10;
  localparam int IN_W      = 16;
  localparam int TERM_W    = 17;
  localparam int ROOT_W    = 16;
  localparam int RAD_W     = 32;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DIV_W     = ROOT_W + 1;
  localparam int QBITS     = 15;
  localparam int MAG_W     = 17;
  localparam int LANES     = 3;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    branch_t                            br;
    logic [LANES-1:0][TERM_W-1:0]       t;
  } sq_side_t;

  typedef struct packed {
    logic                vld;
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
    sq_side_t            side;
  } sq_t;

  typedef struct packed {
    branch_t                            br;
    logic                               use_div;
    logic [QBITS-1:0]                   half;
    logic [LANES-1:0]                   neg;
    logic [LANES-1:0]                   ovf;
    logic [LANES-1:0][MAG_W-1:0]        mulmag;
  } dv_side_t;

  typedef struct packed {
    logic                               vld;
    logic [DIV_W-1:0]                   d;
    logic [LANES-1:0][DIV_W-1:0]        rem;
    logic [LANES-1:0][QBITS-1:0]        dvd;
    logic [LANES-1:0][QBITS-1:0]        q;
    dv_side_t                           side;
  } dv_t;

endpackage
`default_nettype wire

// ===== rtl/core/rmq_sqrt_cell.sv =====
`default_nettype none
module rmq_sqrt_cell
  import rmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire sq_t  a,
  output sq_t       y
);

  sq_t              y_r;
  sq_t              y_nxt;
  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;

  always_comb begin
    rem2  = {a.rem, a.rad[RAD_W-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    y_nxt      = a;
    y_nxt.rad  = {a.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      y_nxt.rem  = REM_W'(rem2 - trial);
      y_nxt.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      y_nxt.rem  = REM_W'(rem2);
      y_nxt.root = {a.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r.vld <= 1'b0;
    end else if (en) begin
      y_r.vld <= y_nxt.vld;
    end
    if (en) begin
      y_r.rad  <= y_nxt.rad;
      y_r.rem  <= y_nxt.rem;
      y_r.root <= y_nxt.root;
      y_r.side <= y_nxt.side;
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/core/rmq_div_cell.sv =====
`default_nettype none
module rmq_div_cell
  import rmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire dv_t  a,
  output dv_t       y
);

  dv_t            y_r;
  dv_t            y_nxt;
  logic [DIV_W:0] r2;

  always_comb begin
    y_nxt = a;
    r2    = '0;
    for (int i = 0; i < LANES; i++) begin
      r2 = {a.rem[i], a.dvd[i][QBITS-1]};
      y_nxt.dvd[i] = {a.dvd[i][QBITS-2:0], 1'b0};
      if (r2 >= {1'b0, a.d}) begin
        y_nxt.rem[i] = DIV_W'(r2 - {1'b0, a.d});
        y_nxt.q[i]   = {a.q[i][QBITS-2:0], 1'b1};
      end else begin
        y_nxt.rem[i] = DIV_W'(r2);
        y_nxt.q[i]   = {a.q[i][QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r.vld <= 1'b0;
    end else if (en) begin
      y_r.vld <= y_nxt.vld;
    end
    if (en) begin
      y_r.d    <= y_nxt.d;
      y_r.rem  <= y_nxt.rem;
      y_r.dvd  <= y_nxt.dvd;
      y_r.q    <= y_nxt.q;
      y_r.side <= y_nxt.side;
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
`default_nettype none
// Converts a 3x3 rotation matrix in signed Q1.14 into a quaternion by
// Shepperd's method. One matrix word is taken every cycle; each result
// passes through one entry stage, sixteen square root cells, one
// scaling stage with the multipliers, fifteen divider cells and
// the output register. The whole pipeline holds while the
// output word is not taken. The threshold register must be written only
// while no word is in flight.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // qx, qy, qz, qw from the lowest bit up
  output logic [63:0]       out_tdata,
  // branch_taken
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [1:0] ADDR_THR = 2'd0;

  logic [THR_W-1:0] thr_r;
  logic             en;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_THR) ? {22'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_THR) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Entry stage.
  logic signed [IN_W-1:0] m [9];
  logic signed [17:0]     tr;
  logic signed [18:0]     radv;
  logic signed [TERM_W-1:0] s01, s02, s12, d21, d02, d10;
  sq_t                    s0_nxt;
  sq_t                    s0_r;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = in_tdata[i*IN_W +: IN_W];
    end
    tr  = 18'(m[0]) + 18'(m[4]) + 18'(m[8]);
    d21 = TERM_W'(m[7]) - TERM_W'(m[5]);
    d02 = TERM_W'(m[2]) - TERM_W'(m[6]);
    d10 = TERM_W'(m[3]) - TERM_W'(m[1]);
    s01 = TERM_W'(m[3]) + TERM_W'(m[1]);
    s02 = TERM_W'(m[2]) + TERM_W'(m[6]);
    s12 = TERM_W'(m[7]) + TERM_W'(m[5]);
    s0_nxt      = '0;
    s0_nxt.vld  = in_tvalid;
    if (tr > $signed({8'd0, thr_r})) begin
      s0_nxt.side.br = BR_TRACE;
      radv = 19'(tr) + 19'sd16384;
      s0_nxt.side.t  = {d10, d02, d21};
    end else if (m[4] > m[0] && m[4] > m[8]) begin
      s0_nxt.side.br = BR_Y;
      radv = 19'(m[4]) - 19'(m[0]) - 19'(m[8]) + 19'sd16384;
      s0_nxt.side.t  = {d02, s12, s01};
    end else if (m[8] > m[0]) begin
      s0_nxt.side.br = BR_Z;
      radv = 19'(m[8]) - 19'(m[0]) - 19'(m[4]) + 19'sd16384;
      s0_nxt.side.t  = {d10, s12, s02};
    end else begin
      s0_nxt.side.br = BR_X;
      radv = 19'(m[0]) - 19'(m[4]) - 19'(m[8]) + 19'sd16384;
      s0_nxt.side.t  = {d21, s02, s01};
    end
    if (radv <= 0) begin
      s0_nxt.rad = '0;
    end else begin
      s0_nxt.rad = {1'b0, radv[16:0], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (en) begin
      s0_r.vld <= s0_nxt.vld;
    end
    if (en) begin
      s0_r.rad  <= s0_nxt.rad;
      s0_r.rem  <= s0_nxt.rem;
      s0_r.root <= s0_nxt.root;
      s0_r.side <= s0_nxt.side;
    end
  end

  sq_t sq [ROOT_W+1];
  assign sq[0] = s0_r;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a     (sq[g]),
      .y     (sq[g+1])
    );
  end

  // Scaling stage.
  sq_t                  sl;
  dv_t                  p_nxt;
  dv_t                  p_r;
  logic [MAG_W-1:0]     mag;
  logic [MAG_W+ROOT_W-1:0] prod;
  logic [MAG_W+ROOT_W-FRAC_BITS-1:0] pm;

  assign sl = sq[ROOT_W];

  always_comb begin
    p_nxt              = '0;
    p_nxt.vld          = sl.vld;
    p_nxt.d            = {sl.root, 1'b0};
    p_nxt.side.br      = sl.side.br;
    p_nxt.side.half    = sl.root[ROOT_W-1:1];
    p_nxt.side.use_div = (sl.side.br == BR_TRACE) || (sl.root > {6'd0, thr_r});
    mag  = '0;
    prod = '0;
    pm   = '0;
    for (int i = 0; i < LANES; i++) begin
      p_nxt.side.neg[i] = sl.side.t[i][TERM_W-1];
      mag  = sl.side.t[i][TERM_W-1] ? MAG_W'(-sl.side.t[i]) : sl.side.t[i];
      p_nxt.side.ovf[i] = {1'b0, mag} >= {p_nxt.d, 1'b0};
      p_nxt.rem[i] = DIV_W'(mag >> 1);
      p_nxt.dvd[i] = {mag[0], {(QBITS-1){1'b0}}};
      prod = mag * sl.root;
      pm   = prod[MAG_W+ROOT_W-1:FRAC_BITS];
      p_nxt.side.mulmag[i] = (pm > 19'd32768) ? MAG_W'(32768) : MAG_W'(pm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.vld <= 1'b0;
    end else if (en) begin
      p_r.vld <= p_nxt.vld;
    end
    if (en) begin
      p_r.d    <= p_nxt.d;
      p_r.rem  <= p_nxt.rem;
      p_r.dvd  <= p_nxt.dvd;
      p_r.q    <= p_nxt.q;
      p_r.side <= p_nxt.side;
    end
  end

  dv_t dv [QBITS+1];
  assign dv[0] = p_r;

  for (genvar g = 0; g < QBITS; g++) begin : g_div
    rmq_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a     (dv[g]),
      .y     (dv[g+1])
    );
  end

  // Output stage.
  dv_t                   dl;
  logic [LANES-1:0][IN_W-1:0] lv;
  logic [MAG_W-1:0]      fm;
  logic [IN_W-1:0]       hv;
  logic [63:0]           data_nxt;
  logic [63:0]           data_r;
  logic [1:0]            br_r;

  assign dl = dv[QBITS];

  always_comb begin
    fm = '0;
    for (int i = 0; i < LANES; i++) begin
      if (!dl.side.use_div) begin
        fm = dl.side.mulmag[i];
      end else if (dl.side.ovf[i]) begin
        fm = MAG_W'(32768);
      end else begin
        fm = {2'b00, dl.q[i]};
      end
      if (dl.side.neg[i]) begin
        lv[i] = IN_W'(-fm);
      end else if (fm > MAG_W'(32767)) begin
        lv[i] = 16'h7fff;
      end else begin
        lv[i] = fm[IN_W-1:0];
      end
    end
    hv = {1'b0, dl.side.half};
    unique case (dl.side.br)
      BR_TRACE: data_nxt = {hv, lv[2], lv[1], lv[0]};
      BR_X:     data_nxt = {lv[2], lv[1], lv[0], hv};
      BR_Y:     data_nxt = {lv[2], lv[1], hv, lv[0]};
      BR_Z:     data_nxt = {lv[2], hv, lv[1], lv[0]};
      default:  data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dl.vld;
    end
    if (en) begin
      data_r <= data_nxt;
      br_r   <= dl.side.br;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = br_r;

  a_trace_w_large: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == BR_TRACE |-> out_tdata[63:48] >= 16'd8192)
    else $error("trace branch gave a small scalar part");

  a_half_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == BR_X |-> !out_tdata[15])
    else $error("x branch gave a negative x component");

  a_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word shown straight after reset");

endmodule
`default_nettype wire

// ===== verif/rotation_matrix_to_quaternion_tb.sv =====
module rotation_matrix_to_quaternion_tb
  import rmq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    branch_t br;
  } quat_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [143:0]  in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [63:0]   out_tdata;
  logic [1:0]    out_tuser;
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [1:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  localparam logic [1:0] ADDR_THRESHOLD = 2'd0;
  localparam int LATENCY = 34;
  localparam int IDLE_LIMIT = 5000;

  quat_t      expected_quats[$];
  logic [9:0] threshold = '0;
  int         failures = 0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         idle_cycles = 0;
  int         branch_hits[4] = '{0, 0, 0, 0};
  bit         stall_enable = 1'b1;

  rotation_matrix_to_quaternion i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned fixed_root(longint v);
    if (v <= 0) return 0;
    return int_sqrt(longint'(v) << FRAC_BITS);
  endfunction

  function automatic longint div_twice_root(longint t, longint unsigned root);
    longint unsigned mag = (t < 0) ? -t : t;
    longint unsigned q = (mag << FRAC_BITS) / (2 * root);
    return (t < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mul_root(longint t, longint unsigned root);
    longint unsigned mag = (t < 0) ? -t : t;
    longint unsigned p = (mag * root) >> FRAC_BITS;
    return (t < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint scale_term(longint t, longint unsigned root);
    if (root > threshold) return div_twice_root(t, root);
    return mul_root(t, root);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic quat_t matrix_to_quat(logic [143:0] d);
    longint m[9];
    longint tr, x, y, z, w;
    longint unsigned root;
    longint one = longint'(1) << FRAC_BITS;
    quat_t q;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
    tr = m[0] + m[4] + m[8];
    if (tr > longint'(threshold)) begin
      root = fixed_root(tr + one);
      w = root >> 1;
      x = div_twice_root(m[7] - m[5], root);
      y = div_twice_root(m[2] - m[6], root);
      z = div_twice_root(m[3] - m[1], root);
      q.br = BR_TRACE;
    end else if (m[4] > m[0] && m[4] > m[8]) begin
      root = fixed_root(m[4] - m[0] - m[8] + one);
      y = root >> 1;
      w = scale_term(m[2] - m[6], root);
      x = scale_term(m[3] + m[1], root);
      z = scale_term(m[7] + m[5], root);
      q.br = BR_Y;
    end else if (m[8] > m[0]) begin
      root = fixed_root(m[8] - m[0] - m[4] + one);
      z = root >> 1;
      w = scale_term(m[3] - m[1], root);
      x = scale_term(m[2] + m[6], root);
      y = scale_term(m[7] + m[5], root);
      q.br = BR_Z;
    end else begin
      root = fixed_root(m[0] - m[4] - m[8] + one);
      x = root >> 1;
      w = scale_term(m[7] - m[5], root);
      y = scale_term(m[3] + m[1], root);
      z = scale_term(m[2] + m[6], root);
      q.br = BR_X;
    end
    q.qx = clip16(x);
    q.qy = clip16(y);
    q.qz = clip16(z);
    q.qw = clip16(w);
    return q;
  endfunction

  // Checker and receiver stall pattern.
  always @(posedge clk) begin
    quat_t e;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        words_checked <= words_checked + 1;
        if (expected_quats.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          failures++;
        end else begin
          e = expected_quats.pop_front();
          if (out_tdata[15:0] !== e.qx) begin
            $error("qx expected %0d actual %0d", e.qx, $signed(out_tdata[15:0]));
            failures++;
          end
          if (out_tdata[31:16] !== e.qy) begin
            $error("qy expected %0d actual %0d", e.qy, $signed(out_tdata[31:16]));
            failures++;
          end
          if (out_tdata[47:32] !== e.qz) begin
            $error("qz expected %0d actual %0d", e.qz, $signed(out_tdata[47:32]));
            failures++;
          end
          if (out_tdata[63:48] !== e.qw) begin
            $error("qw expected %0d actual %0d", e.qw, $signed(out_tdata[63:48]));
            failures++;
          end
          if (out_tuser !== e.br) begin
            $error("branch_taken expected %0d actual %0d", e.br, out_tuser);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    int w;
    w = 0;
    forever begin
      @(posedge clk);
      if (w > 0) begin
        w--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (stall_enable && (out_tvalid && out_tready || !out_tvalid))
          w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_matrix(logic [143:0] d);
    int gap;
    gap = stall_enable ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(d));
    branch_hits[matrix_to_quat(d).br]++;
    words_sent++;
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_THRESHOLD;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    threshold = value[9:0];
    @(posedge clk);
  endtask

  function automatic logic [143:0] pack_matrix(int m00, int m01, int m02, int m10,
                                                 int m11, int m12, int m20, int m21,
                                                 int m22);
    return {m22[15:0], m21[15:0], m20[15:0], m12[15:0], m11[15:0], m10[15:0],
            m02[15:0], m01[15:0], m00[15:0]};
  endfunction

  function automatic int rnd_elem();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int near(int v, int spread);
    int r = v + int'($urandom_range(0, 2 * spread)) - spread;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic test_directed_extremes();
    send_matrix(pack_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_matrix(pack_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    send_matrix(pack_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    send_matrix(pack_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    send_matrix({144{1'b1}});
    send_matrix({144{1'b0}});
    send_matrix(pack_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(pack_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768));
    send_matrix(pack_matrix(-32768, 32767, -32768, 32767, -32768, 32767, -32768,
                            32767, -32768));
    send_matrix(pack_matrix(-32768, 32767, -32768, -32768, -32768, 32767, 32767,
                            -32768, -32768));
    send_matrix(pack_matrix(-30000, 32767, 32767, 32767, -30000, 32767, 32767, 32767,
                            -30000));
    send_matrix(pack_matrix(-32768, -32768, 32767, 32767, -32768, 0, -32768, 32767, 0));
    send_matrix(pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(pack_matrix(1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(pack_matrix(-16384, 100, 200, 300, -16384, 400, 500, 600, -16384));
    send_matrix(pack_matrix(-20000, 5, -7, 9, -20000, 11, -13, 17, -20000));
    drain_pipeline();
  endtask

  task automatic test_threshold_settings();
    logic [31:0] settings[5] = '{32'h3FF, 32'hFFFF_FC01, 32'd1, 32'd512, 32'd0};
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      send_matrix(pack_matrix(int'(threshold), 0, 0, 0, 0, 0, 0, 0, 0));
      send_matrix(pack_matrix(int'(threshold) + 1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_matrix(pack_matrix(-16384, 3000, -3000, 2000, -16384, -1000, 1000, 500,
                              -16384 + int'(threshold)));
      for (int i = 0; i < 40; i++) send_matrix(random_matrix());
      drain_pipeline();
    end
  endtask

  function automatic logic [143:0] random_matrix();
    int d0, d1, d2, s;
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      1: begin
        s = $urandom_range(0, 3) == 0 ? 32767 : 2000;
        return pack_matrix(near(16384, s), near(0, 16384), near(0, 16384),
                           near(0, 16384), near(16384, s), near(0, 16384),
                           near(0, 16384), near(0, 16384), near(16384, s));
      end
      2, 3, 4: begin
        // Negative trace so that one of the diagonal branches is taken.
        d0 = near(-12000, 12000);
        d1 = near(-12000, 12000);
        d2 = near(-12000, 12000);
        if ($urandom_range(0, 4) == 0) d1 = d0;
        if ($urandom_range(0, 4) == 0) d2 = d0;
        if ($urandom_range(0, 6) == 0) begin
          d0 = near(-16384, 40);
          d1 = near(-16384, 40);
          d2 = near(-16384, 40);
        end
        return pack_matrix(d0, near(0, 20000), near(0, 20000), near(0, 20000), d1,
                           near(0, 20000), near(0, 20000), near(0, 20000), d2);
      end
      default: begin
        d0 = rnd_elem();
        return pack_matrix(d0, rnd_elem(), rnd_elem(), rnd_elem(),
                           near(-d0, 600), rnd_elem(), rnd_elem(), rnd_elem(),
                           near(0, 600));
      end
    endcase
  endfunction

  task automatic test_random_traffic();
    write_threshold($urandom_range(0, 1023));
    for (int i = 0; i < 600; i++) send_matrix(random_matrix());
    drain_pipeline();
    write_threshold($urandom_range(0, 40));
    for (int i = 0; i < 400; i++) begin
      if (i % 100 == 0) stall_enable = ~stall_enable;
      send_matrix(random_matrix());
    end
    stall_enable = 1'b1;
    drain_pipeline();
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 110; i++) send_matrix(random_matrix());
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    for (int i = 0; i < 110; i++) send_matrix(random_matrix());
    drain_pipeline();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_threshold_settings();
    test_random_traffic();
    test_pause_until_drained();
    $display("Sent %0d matrices, checked %0d quaternions over several thresholds.",
             words_sent, words_checked);
    $display("Branch counts: trace %0d, x %0d, y %0d, z %0d.", branch_hits[0],
             branch_hits[1], branch_hits[2], branch_hits[3]);
    if (failures == 0 && expected_quats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
